### hw/rtl/emr_pkg.sv
package emr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    // shared multiplier operand/destination selects
    localparam logic [2:0] MUL_AA  = 3'd0;  // a*a     -> a2
    localparam logic [2:0] MUL_BB  = 3'd1;  // b*b     -> b2
    localparam logic [2:0] MUL_A4  = 3'd2;  // a2*a2   -> a4 (also loads a2+b2)
    localparam logic [2:0] MUL_AAY = 3'd3;  // a2*y    -> aay
    localparam logic [2:0] MUL_BBA = 3'd4;  // b2*a    -> bba
    localparam logic [2:0] MUL_BBX = 3'd5;  // b2*x    -> bbx
    localparam logic [2:0] MUL_XX  = 3'd6;  // x*x     -> xx
    localparam logic [2:0] MUL_XXS = 3'd7;  // xx*(a2+b2) -> lhs

    // datapath actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_LATCH     = 3'd1;
    localparam logic [2:0] ACT_INIT      = 3'd2;
    localparam logic [2:0] ACT_R1_UPD    = 3'd3;
    localparam logic [2:0] ACT_R2_UPD    = 3'd4;
    localparam logic [2:0] ACT_EMIT      = 3'd5;
    localparam logic [2:0] ACT_EMIT_NULL = 3'd6;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] mul_op;
        logic [2:0] act;
        logic       last;
    } emr_cmd_t;

    typedef struct packed {
        logic lhs_le;    // x*x*(a2+b2) <= a^4
        logic lhs_lt;    // x*x*(a2+b2) <  a^4
        logic out_free;  // output register can take a transaction
    } emr_status_t;

endpackage

### hw/rtl/ellipse_midpoint_rasterizer_top.sv
// Midpoint ellipse rasterizer. A start transaction (tuser = 0) latches center and radii
// (a radius of 0 counts as 1) and returns the set at (0,b); each step transaction
// (tuser = 1) advances one iteration and returns one set: xc+x, xc-x, yc+y, yc-y, with
// tlast on the final set of the ellipse. A step with no ellipse in progress returns a
// set with tuser = 0 and zero coordinates. Items are handled one at a time; all products
// go through one shared multiplier, one product per cycle, which sets the rate; an item
// also waits in its emit state while the output register holds a set that m_axis_tready
// has not yet taken. The next item is accepted while a finished set still waits in the
// output register.
module ellipse_midpoint_rasterizer_top
    import emr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, radius_a, radius_b
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // x_plus, x_minus, y_plus, y_minus
    output logic [((4*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    // valid_res
    output logic m_axis_tuser,
    output logic m_axis_tlast
);

    localparam int OUT_DATA_W = ((4 * (COORD_BITS + 1) + 7) / 8) * 8;
    localparam int CY_LO      = COORD_BITS;
    localparam int RA_LO      = 2 * COORD_BITS;
    localparam int RB_LO      = 2 * COORD_BITS + RADIUS_BITS;

    emr_cmd_t    cmd;
    emr_status_t status;

    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [RADIUS_BITS-1:0]       radius_a;
    logic [RADIUS_BITS-1:0]       radius_b;
    logic signed [COORD_BITS:0]   x_plus;
    logic signed [COORD_BITS:0]   x_minus;
    logic signed [COORD_BITS:0]   y_plus;
    logic signed [COORD_BITS:0]   y_minus;

    assign center_x = s_axis_tdata[COORD_BITS-1:0];
    assign center_y = s_axis_tdata[CY_LO +: COORD_BITS];
    assign radius_a = s_axis_tdata[RA_LO +: RADIUS_BITS];
    assign radius_b = s_axis_tdata[RB_LO +: RADIUS_BITS];

    emr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .action   (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    emr_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_a  (radius_a),
        .radius_b  (radius_b),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .valid_res (m_axis_tuser),
        .x_plus    (x_plus),
        .x_minus   (x_minus),
        .y_plus    (y_plus),
        .y_minus   (y_minus),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_W'({y_minus, y_plus, x_minus, x_plus});

endmodule

### hw/rtl/emr_ctrl.sv
module emr_ctrl
    import emr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  emr_status_t status,
    output emr_cmd_t    cmd
);

    localparam logic [4:0] S_WAIT      = 5'd0;
    localparam logic [4:0] S_AA        = 5'd1;
    localparam logic [4:0] S_BB        = 5'd2;
    localparam logic [4:0] S_A4        = 5'd3;
    localparam logic [4:0] S_AAY       = 5'd4;
    localparam logic [4:0] S_BBA       = 5'd5;
    localparam logic [4:0] S_INIT      = 5'd6;
    localparam logic [4:0] S_R1_XXS    = 5'd7;
    localparam logic [4:0] S_R1_BBX    = 5'd8;
    localparam logic [4:0] S_R1_AAY    = 5'd9;
    localparam logic [4:0] S_R1_UPD    = 5'd10;
    localparam logic [4:0] S_R2_AAY    = 5'd11;
    localparam logic [4:0] S_R2_UPD    = 5'd12;
    localparam logic [4:0] S_R2_XX     = 5'd13;
    localparam logic [4:0] S_R2_XXS    = 5'd14;
    localparam logic [4:0] S_EMIT      = 5'd15;
    localparam logic [4:0] S_EMIT_R2   = 5'd16;
    localparam logic [4:0] S_EMIT_NULL = 5'd17;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       accept;

    assign in_ready = (state_reg == S_WAIT);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '{mul_en: 1'b0, mul_op: MUL_AA, act: ACT_NONE, last: 1'b0};
        unique case (state_reg)
            S_WAIT:
            begin
                if (accept)
                begin
                    if (!action)
                    begin
                        cmd.act    = ACT_LATCH;
                        state_next = S_AA;
                    end
                    else if (phase_reg == PH_R1)
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_XX;
                        state_next = S_R1_XXS;
                    end
                    else if (phase_reg == PH_R2)
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_op = MUL_BBX;
                        state_next = S_R2_AAY;
                    end
                    else
                    begin
                        state_next = S_EMIT_NULL;
                    end
                end
            end
            S_AA:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_AA;
                state_next = S_BB;
            end
            S_BB:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_BB;
                state_next = S_A4;
            end
            S_A4:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_A4;
                state_next = S_AAY;
            end
            S_AAY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_AAY;
                state_next = S_BBA;
            end
            S_BBA:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_BBA;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.act    = ACT_INIT;
                phase_next = PH_R1;
                state_next = S_EMIT;
            end
            S_R1_XXS:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_XXS;
                state_next = S_R1_BBX;
            end
            S_R1_BBX:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_BBX;
                state_next = S_R1_AAY;
            end
            S_R1_AAY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_AAY;
                state_next = S_R1_UPD;
            end
            S_R1_UPD:
            begin
                cmd.act    = ACT_R1_UPD;
                phase_next = status.lhs_le ? PH_R1 : PH_R2;
                state_next = S_EMIT;
            end
            S_R2_AAY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_AAY;
                state_next = S_R2_UPD;
            end
            S_R2_UPD:
            begin
                cmd.act    = ACT_R2_UPD;
                state_next = S_R2_XX;
            end
            S_R2_XX:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_XX;
                state_next = S_R2_XXS;
            end
            S_R2_XXS:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_XXS;
                state_next = S_EMIT_R2;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.act    = ACT_EMIT;
                    state_next = S_WAIT;
                end
            end
            S_EMIT_R2:
            begin
                if (status.out_free)
                begin
                    cmd.act  = ACT_EMIT;
                    cmd.last = status.lhs_lt;
                    if (status.lhs_lt)
                    begin
                        phase_next = PH_IDLE;
                    end
                    state_next = S_WAIT;
                end
            end
            S_EMIT_NULL:
            begin
                if (status.out_free)
                begin
                    cmd.act    = ACT_EMIT_NULL;
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

endmodule

### hw/rtl/emr_datapath.sv
module emr_datapath
    import emr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  emr_cmd_t                     cmd,
    output emr_status_t                  status,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic [RADIUS_BITS-1:0]       radius_a,
    input  logic [RADIUS_BITS-1:0]       radius_b,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         valid_res,
    output logic signed [COORD_BITS:0]   x_plus,
    output logic signed [COORD_BITS:0]   x_minus,
    output logic signed [COORD_BITS:0]   y_plus,
    output logic signed [COORD_BITS:0]   y_minus,
    output logic                         last
);

    localparam int R   = RADIUS_BITS;
    localparam int OW  = COORD_BITS + 1;
    localparam int OXW = R + 2;
    localparam int OYW = R + 3;
    localparam int MW  = 2 * R + 3;
    localparam int PW  = 2 * MW;
    localparam int DW  = 3 * R + 6;

    logic signed [COORD_BITS-1:0] xc_reg;
    logic signed [COORD_BITS-1:0] yc_reg;
    logic [R-1:0]                 a_reg;
    logic [R-1:0]                 b_reg;
    logic [2*R-1:0]               a2_reg;
    logic [2*R-1:0]               b2_reg;
    logic [2*R:0]                 s_reg;
    logic [4*R-1:0]               a4_reg;
    logic signed [OXW-1:0]        x_reg;
    logic signed [OYW-1:0]        y_reg;
    logic signed [DW-1:0]         d_reg;
    logic signed [MW-1:0]         xx_reg;
    logic signed [PW-1:0]         lhs_reg;
    logic signed [DW-1:0]         bbx_reg;
    logic signed [DW-1:0]         aay_reg;
    logic signed [DW-1:0]         bba_reg;

    logic                         out_valid_reg;
    logic                         valid_res_reg;
    logic signed [OW-1:0]         x_plus_reg;
    logic signed [OW-1:0]         x_minus_reg;
    logic signed [OW-1:0]         y_plus_reg;
    logic signed [OW-1:0]         y_minus_reg;
    logic                         last_reg;

    logic [R-1:0]                 a_fix;
    logic [R-1:0]                 b_fix;
    logic signed [MW-1:0]         mul_a;
    logic signed [MW-1:0]         mul_b;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         a4_ext;

    logic signed [DW-1:0]         a2_w;
    logic signed [DW-1:0]         b2_w;
    logic signed [DW-1:0]         a2q;
    logic signed [DW-1:0]         b2q;
    logic signed [DW-1:0]         bbx2;
    logic signed [DW-1:0]         aay2;
    logic signed [DW-1:0]         d_init;
    logic signed [DW-1:0]         d_r1_lo;
    logic signed [DW-1:0]         d_r1_hi;
    logic signed [DW-1:0]         d_r2_init;
    logic signed [DW-1:0]         d_r2_lo;
    logic signed [DW-1:0]         d_r2_hi;
    logic                         d_le0;

    logic signed [OW-1:0]         xc_ext;
    logic signed [OW-1:0]         yc_ext;
    logic signed [OW-1:0]         x_ext;
    logic signed [OW-1:0]         y_ext;

    assign a_fix = (radius_a == '0) ? R'(1) : radius_a;
    assign b_fix = (radius_b == '0) ? R'(1) : radius_b;

    // shared multiplier, operands chosen per command
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_AA:
            begin
                mul_a = MW'(a_reg);
                mul_b = MW'(a_reg);
            end
            MUL_BB:
            begin
                mul_a = MW'(b_reg);
                mul_b = MW'(b_reg);
            end
            MUL_A4:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(a2_reg);
            end
            MUL_AAY:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(y_reg);
            end
            MUL_BBA:
            begin
                mul_a = MW'(b2_reg);
                mul_b = MW'(a_reg);
            end
            MUL_BBX:
            begin
                mul_a = MW'(b2_reg);
                mul_b = MW'(x_reg);
            end
            MUL_XX:
            begin
                mul_a = MW'(x_reg);
                mul_b = MW'(x_reg);
            end
            MUL_XXS:
            begin
                mul_a = xx_reg;
                mul_b = MW'(s_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign a4_ext = PW'(a4_reg);

    assign a2_w  = DW'(a2_reg);
    assign b2_w  = DW'(b2_reg);
    assign a2q   = DW'(a2_reg >> 2);
    assign b2q   = DW'(b2_reg >> 2);
    assign bbx2  = bbx_reg <<< 1;
    assign aay2  = aay_reg <<< 1;
    assign d_le0 = (d_reg <= 0);

    assign d_init    = b2_w - aay_reg + a2q;
    assign d_r1_lo   = d_reg + bbx2 + b2_w + (b2_w <<< 1);
    assign d_r1_hi   = d_reg + bbx2 - aay2 + (a2_w <<< 1) + b2_w + (b2_w <<< 1);
    assign d_r2_init = a2_w - bba_reg + b2q;
    assign d_r2_lo   = d_reg + aay2 + a2_w + (a2_w <<< 1);
    assign d_r2_hi   = d_reg + aay2 - bbx2 + (b2_w <<< 1) + a2_w + (a2_w <<< 1);

    assign xc_ext = OW'(xc_reg);
    assign yc_ext = OW'(yc_reg);
    assign x_ext  = OW'(x_reg);
    assign y_ext  = OW'(y_reg);

    assign status.lhs_le   = (lhs_reg <= a4_ext);
    assign status.lhs_lt   = (lhs_reg < a4_ext);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_op)
                MUL_AA:  a2_reg <= prod[2*R-1:0];
                MUL_BB:  b2_reg <= prod[2*R-1:0];
                MUL_A4:
                begin
                    a4_reg <= prod[4*R-1:0];
                    s_reg  <= {1'b0, a2_reg} + {1'b0, b2_reg};
                end
                MUL_AAY: aay_reg <= prod[DW-1:0];
                MUL_BBA: bba_reg <= prod[DW-1:0];
                MUL_BBX: bbx_reg <= prod[DW-1:0];
                MUL_XX:  xx_reg  <= prod[MW-1:0];
                MUL_XXS: lhs_reg <= prod;
                default: ;
            endcase
        end

        case (cmd.act)
            ACT_LATCH:
            begin
                xc_reg <= center_x;
                yc_reg <= center_y;
                a_reg  <= a_fix;
                b_reg  <= b_fix;
                x_reg  <= '0;
                y_reg  <= OYW'(b_fix);
            end
            ACT_INIT:
            begin
                d_reg <= d_init;
            end
            ACT_R1_UPD:
            begin
                if (status.lhs_le)
                begin
                    if (d_le0)
                    begin
                        d_reg <= d_r1_lo;
                    end
                    else
                    begin
                        d_reg <= d_r1_hi;
                        y_reg <= y_reg - OYW'(1);
                    end
                    x_reg <= x_reg + OXW'(1);
                end
                else
                begin
                    x_reg <= OXW'(a_reg);
                    y_reg <= '0;
                    d_reg <= d_r2_init;
                end
            end
            ACT_R2_UPD:
            begin
                if (d_le0)
                begin
                    d_reg <= d_r2_lo;
                end
                else
                begin
                    d_reg <= d_r2_hi;
                    x_reg <= x_reg - OXW'(1);
                end
                y_reg <= y_reg + OYW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.act == ACT_EMIT || cmd.act == ACT_EMIT_NULL)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act == ACT_EMIT)
        begin
            valid_res_reg <= 1'b1;
            x_plus_reg    <= xc_ext + x_ext;
            x_minus_reg   <= xc_ext - x_ext;
            y_plus_reg    <= yc_ext + y_ext;
            y_minus_reg   <= yc_ext - y_ext;
            last_reg      <= cmd.last;
        end
        else if (cmd.act == ACT_EMIT_NULL)
        begin
            valid_res_reg <= 1'b0;
            x_plus_reg    <= '0;
            x_minus_reg   <= '0;
            y_plus_reg    <= '0;
            y_minus_reg   <= '0;
            last_reg      <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign x_plus    = x_plus_reg;
    assign x_minus   = x_minus_reg;
    assign y_plus    = y_plus_reg;
    assign y_minus   = y_minus_reg;
    assign last      = last_reg;

endmodule
